/* rtl/sfir_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfir_pkg
// Shared constants, codes and types of the stereo Q15 FIR filter.
// ----------------------------------------------------------------------------
package sfir_pkg;

   // Default sizes of the filter.
   localparam int TAPS_DEF        = 81;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int TABLES_DEF      = 3;

   // Fixed field widths.
   localparam int COEF_BITS = 16;
   localparam int MODE_W    = 4;
   localparam int TABLE_W   = 2;
   localparam int INDEX_W   = 7;

   // Accumulator and output scaling.
   localparam int ACC_W    = 32;
   localparam int RND_HALF = 1 << 14;
   localparam int Q_SHIFT  = 15;

   // Item commands.
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_COEF   = 1'b1;

   // Mode register codes.
   localparam logic [MODE_W-1:0] MODE_MUTE   = 4'd0;
   localparam logic [MODE_W-1:0] MODE_BYPASS = 4'd1;
   localparam logic [MODE_W-1:0] MODE_LOW    = 4'd2;
   localparam logic [MODE_W-1:0] MODE_BAND   = 4'd4;
   localparam logic [MODE_W-1:0] MODE_HIGH   = 4'd8;

   // Coefficient table numbers.
   localparam logic [TABLE_W-1:0] TABLE_LOW  = 2'd0;
   localparam logic [TABLE_W-1:0] TABLE_BAND = 2'd1;
   localparam logic [TABLE_W-1:0] TABLE_HIGH = 2'd2;

   // Control that travels with one tap from the sequencer into a MAC lane.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
      logic live;
   } mac_ctl_type;

endpackage
`default_nettype wire

/* rtl/sfir_hist.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfir_hist
// Circular sample history of one channel: one write and one registered read.
// ----------------------------------------------------------------------------
module sfir_hist #(
   parameter int DEPTH = 80,
   parameter int AW    = 7,
   parameter int WIDTH = 16
) (
   input  wire logic                    clock,
   input  wire logic                    wr_en,
   input  wire logic [AW-1:0]           wr_addr,
   input  wire logic signed [WIDTH-1:0] wr_data,
   input  wire logic                    rd_en,
   input  wire logic [AW-1:0]           rd_addr,
   output      logic signed [WIDTH-1:0] rd_data
);

   logic signed [WIDTH-1:0] mem [DEPTH];
   logic signed [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/sfir_mac.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfir_mac
// One channel lane: multiply, saturating accumulate, round, shift and clamp.
// ----------------------------------------------------------------------------
module sfir_mac #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire sfir_pkg::mac_ctl_type                   ctl,
   input  wire logic signed [SAMPLE_BITS-1:0]           newest,
   input  wire logic signed [SAMPLE_BITS-1:0]           hist,
   input  wire logic signed [sfir_pkg::COEF_BITS-1:0]   coef,
   output      logic signed [SAMPLE_BITS-1:0]           res,
   output      logic                                    done
);
   import sfir_pkg::*;

   localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
   localparam int SUM_W  = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 1;
   localparam int RSUM_W = ACC_W + 1;
   localparam int SH_W   = ACC_W - Q_SHIFT;
   localparam int SHX_W  = (SH_W > SAMPLE_BITS) ? SH_W : SAMPLE_BITS;

   localparam logic signed [SUM_W-1:0] ACC_MAX_S =
      {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] ACC_MIN_S =
      {{(SUM_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};
   localparam logic signed [RSUM_W-1:0] RACC_MAX_S = {2'b00, {(ACC_W-1){1'b1}}};
   localparam logic signed [RSUM_W-1:0] RACC_MIN_S = {2'b11, {(ACC_W-1){1'b0}}};
   localparam logic signed [RSUM_W-1:0] RND_POS = RSUM_W'(RND_HALF);
   localparam logic signed [RSUM_W-1:0] RND_NEG = RSUM_W'(-RND_HALF);
   localparam logic signed [SHX_W-1:0] OUT_MAX_S =
      {{(SHX_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SHX_W-1:0] OUT_MIN_S =
      {{(SHX_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

   // Multiply stage.
   logic signed [SAMPLE_BITS-1:0] operand;
   logic signed [PROD_W-1:0]      prod_in;
   logic signed [PROD_W-1:0]      prod_ff;
   mac_ctl_type                   ctl2_ff;

   // Accumulate stage.
   logic signed [ACC_W-1:0] acc_op;
   logic signed [SUM_W-1:0] sum;
   logic signed [ACC_W-1:0] acc_in;
   logic signed [ACC_W-1:0] acc_ff;
   logic                    last_ff;

   // Rounding stage.
   logic signed [RSUM_W-1:0]      rsum;
   logic signed [ACC_W-1:0]       racc;
   logic signed [SHX_W-1:0]       shifted;
   logic signed [SAMPLE_BITS-1:0] res_in;
   logic signed [SAMPLE_BITS-1:0] res_ff;
   logic                          done_ff;

   always_comb begin
      if (ctl.first) begin
         operand = newest;
      end else if (ctl.live) begin
         operand = hist;
      end else begin
         operand = '0;
      end
      prod_in = operand * coef;
   end

   always_comb begin
      acc_op = ctl2_ff.first ? '0 : acc_ff;
      sum    = SUM_W'(acc_op) + SUM_W'(prod_ff);
      if (sum > ACC_MAX_S) begin
         acc_in = ACC_MAX_S[ACC_W-1:0];
      end else if (sum < ACC_MIN_S) begin
         acc_in = ACC_MIN_S[ACC_W-1:0];
      end else begin
         acc_in = sum[ACC_W-1:0];
      end
   end

   // Add half an output LSB with the sign of the accumulator, then a floor shift and a clamp to the sample range.
   always_comb begin
      rsum = RSUM_W'(acc_ff) + (acc_ff[ACC_W-1] ? RND_NEG : RND_POS);
      if (rsum > RACC_MAX_S) begin
         racc = RACC_MAX_S[ACC_W-1:0];
      end else if (rsum < RACC_MIN_S) begin
         racc = RACC_MIN_S[ACC_W-1:0];
      end else begin
         racc = rsum[ACC_W-1:0];
      end
      shifted = SHX_W'($signed(racc[ACC_W-1:Q_SHIFT]));
      if (shifted > OUT_MAX_S) begin
         res_in = OUT_MAX_S[SAMPLE_BITS-1:0];
      end else if (shifted < OUT_MIN_S) begin
         res_in = OUT_MIN_S[SAMPLE_BITS-1:0];
      end else begin
         res_in = shifted[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
         last_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         ctl2_ff <= ctl;
         last_ff <= ctl2_ff.valid & ctl2_ff.last;
         done_ff <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.valid) begin
         prod_ff <= prod_in;
      end
      if (ctl2_ff.valid) begin
         acc_ff <= acc_in;
      end
      if (last_ff) begin
         res_ff <= res_in;
      end
   end

   assign res  = res_ff;
   assign done = done_ff;

endmodule
`default_nettype wire

/* rtl/stereo_fir_filter_q15.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_fir_filter_q15
// Stereo Q15 FIR filter with three loadable coefficient tables.
// ----------------------------------------------------------------------------
// A request beat carries either a stereo sample pair (command sample) or one
// coefficient write (command coef). A coefficient write returns no response.
// Every sample beat returns exactly one response beat with the left and
// right outputs, selected by the mode register (csr_wr_en, csr_wr_data),
// which is to be written only while the block is idle; the block does not
// enforce this. In a filter mode both channel lanes run side by side, one
// tap per cycle, with the coefficient memory read once per tap for both
// lanes. A filter beat passes the tap sequencer, the coefficient and history
// reads, the lane product, accumulator and result registers and the holding
// stage into the output register; the next request is taken once the result
// enters the output register. Mute and bypass beats go straight to the
// holding stage. While a response waits in the output register, the next
// request is already taken and processed into the holding stage; req_stall
// rises only while a sample beat is in flight. Reset sets the mode to mute;
// history reads as zero and coefficient tables are undefined until written.
// ----------------------------------------------------------------------------
module stereo_fir_filter_q15 #(
   parameter int TAPS        = sfir_pkg::TAPS_DEF,
   parameter int SAMPLE_BITS = sfir_pkg::SAMPLE_BITS_DEF,
   parameter int TABLES      = sfir_pkg::TABLES_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_wr_en,
   input  wire logic [sfir_pkg::MODE_W-1:0]            csr_wr_data,
   input  wire logic                                   req_valid,
   output      logic                                   req_stall,
   input  wire logic                                   req_command,
   input  wire logic signed [SAMPLE_BITS-1:0]          req_left_sample,
   input  wire logic signed [SAMPLE_BITS-1:0]          req_right_sample,
   input  wire logic [sfir_pkg::TABLE_W-1:0]           req_coef_table,
   input  wire logic [sfir_pkg::INDEX_W-1:0]           req_coef_index,
   input  wire logic signed [sfir_pkg::COEF_BITS-1:0]  req_coef_value,
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_stall,
   output      logic signed [SAMPLE_BITS-1:0]          rsp_left_out,
   output      logic signed [SAMPLE_BITS-1:0]          rsp_right_out
);
   import sfir_pkg::*;

   localparam int HDEPTH = TAPS - 1;
   localparam int HA_W   = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
   localparam int TAP_W  = $clog2(TAPS);
   localparam int CDEPTH = TABLES * TAPS;
   localparam int CA_W   = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;

   // Mode register.
   logic [MODE_W-1:0] mode_ff;

   // Request decode.
   logic               req_accept;
   logic               coef_we;
   logic [CA_W-1:0]    coef_waddr;
   logic [TABLE_W-1:0] sel_table;
   logic               sel_filter;
   logic               start_run;

   // Tap sequencer.
   logic             busy_ff;
   logic             run_ff;
   logic [TAP_W-1:0] tap_ff;
   logic [CA_W-1:0]  caddr_ff;
   logic [HA_W-1:0]  rdp_ff;
   logic [HA_W-1:0]  wrp_ff;
   logic [TAP_W-1:0] fill_ff;
   logic             hwr_ff;
   logic             tap_last;
   logic [HA_W-1:0]  wrp_dec;
   logic [HA_W-1:0]  rdp_dec;
   logic [HA_W-1:0]  wrp_inc;
   mac_ctl_type      ctl_in;
   mac_ctl_type      ctl_ff;

   logic signed [SAMPLE_BITS-1:0] new_l_ff;
   logic signed [SAMPLE_BITS-1:0] new_r_ff;

   // Coefficient memory.
   logic signed [COEF_BITS-1:0] coef_mem [CDEPTH];
   logic signed [COEF_BITS-1:0] coef_rd_ff;

   // Lane data.
   logic signed [SAMPLE_BITS-1:0] hist_l;
   logic signed [SAMPLE_BITS-1:0] hist_r;
   logic signed [SAMPLE_BITS-1:0] res_l;
   logic signed [SAMPLE_BITS-1:0] res_r;
   logic                          done_l;
   logic                          done_r;

   // Merge stage and output register.
   logic                          pend_valid_ff;
   logic signed [SAMPLE_BITS-1:0] pend_l_ff;
   logic signed [SAMPLE_BITS-1:0] pend_r_ff;
   logic                          out_valid_ff;
   logic signed [SAMPLE_BITS-1:0] out_l_ff;
   logic signed [SAMPLE_BITS-1:0] out_r_ff;
   logic                          move_out;

   assign req_stall  = busy_ff;
   assign req_accept = req_valid & ~busy_ff;

   always_comb begin
      unique case (mode_ff)
         MODE_LOW: begin
            sel_table  = TABLE_LOW;
            sel_filter = (int'(TABLE_LOW) < TABLES);
         end
         MODE_BAND: begin
            sel_table  = TABLE_BAND;
            sel_filter = (int'(TABLE_BAND) < TABLES);
         end
         MODE_HIGH: begin
            sel_table  = TABLE_HIGH;
            sel_filter = (int'(TABLE_HIGH) < TABLES);
         end
         default: begin
            sel_table  = TABLE_LOW;
            sel_filter = 1'b0;
         end
      endcase
   end

   assign start_run  = req_accept & (req_command == CMD_SAMPLE) & sel_filter;
   assign coef_we    = req_accept & (req_command == CMD_COEF)
                       & (int'(req_coef_table) < TABLES) & (int'(req_coef_index) < TAPS);
   assign coef_waddr = CA_W'(int'(req_coef_table) * TAPS + int'(req_coef_index));

   // Circular pointer arithmetic over the history depth.
   assign wrp_dec  = (wrp_ff == '0) ? HA_W'(HDEPTH - 1) : wrp_ff - 1'b1;
   assign rdp_dec  = (rdp_ff == '0) ? HA_W'(HDEPTH - 1) : rdp_ff - 1'b1;
   assign wrp_inc  = (wrp_ff == HA_W'(HDEPTH - 1)) ? '0 : wrp_ff + 1'b1;
   assign tap_last = (tap_ff == TAP_W'(TAPS - 1));

   // A history slot counts only once it has been written since reset.
   always_comb begin
      ctl_in.valid = run_ff;
      ctl_in.first = (tap_ff == '0);
      ctl_in.last  = tap_last;
      ctl_in.live  = (tap_ff <= fill_ff);
   end

   assign move_out = pend_valid_ff & (~out_valid_ff | ~rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_MUTE;
         busy_ff       <= 1'b0;
         run_ff        <= 1'b0;
         tap_ff        <= '0;
         wrp_ff        <= '0;
         fill_ff       <= '0;
         hwr_ff        <= 1'b0;
         ctl_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         ctl_ff <= ctl_in;

         if (start_run) begin
            run_ff <= 1'b1;
            tap_ff <= '0;
         end else if (run_ff) begin
            tap_ff <= tap_ff + 1'b1;
            if (tap_last) begin
               run_ff <= 1'b0;
            end
         end

         // The newest sample enters the history once all taps have been read, or at once in mute and bypass.
         if (req_accept & (req_command == CMD_SAMPLE) & ~sel_filter) begin
            hwr_ff <= 1'b1;
         end else if (run_ff & tap_last) begin
            hwr_ff <= 1'b1;
         end else if (hwr_ff) begin
            hwr_ff  <= 1'b0;
            wrp_ff  <= wrp_inc;
            if (fill_ff != TAP_W'(TAPS - 1)) begin
               fill_ff <= fill_ff + 1'b1;
            end
         end

         if (req_accept & (req_command == CMD_SAMPLE)) begin
            busy_ff <= 1'b1;
         end else if (move_out) begin
            busy_ff <= 1'b0;
         end

         if (req_accept & (req_command == CMD_SAMPLE) & ~sel_filter) begin
            pend_valid_ff <= 1'b1;
         end else if (done_l) begin
            pend_valid_ff <= 1'b1;
         end else if (move_out) begin
            pend_valid_ff <= 1'b0;
         end

         if (move_out) begin
            out_valid_ff <= 1'b1;
         end else if (~rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept & (req_command == CMD_SAMPLE)) begin
         new_l_ff <= req_left_sample;
         new_r_ff <= req_right_sample;
      end
      if (start_run) begin
         caddr_ff <= CA_W'(int'(sel_table) * TAPS);
         rdp_ff   <= wrp_dec;
      end else if (run_ff) begin
         caddr_ff <= caddr_ff + 1'b1;
         if (tap_ff != '0) begin
            rdp_ff <= rdp_dec;
         end
      end

      if (req_accept & (req_command == CMD_SAMPLE) & ~sel_filter) begin
         if (mode_ff == MODE_BYPASS) begin
            pend_l_ff <= req_left_sample;
            pend_r_ff <= req_right_sample;
         end else begin
            pend_l_ff <= '0;
            pend_r_ff <= '0;
         end
      end else if (done_l) begin
         pend_l_ff <= res_l;
         pend_r_ff <= res_r;
      end

      if (move_out) begin
         out_l_ff <= pend_l_ff;
         out_r_ff <= pend_r_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_waddr] <= req_coef_value;
      end
      if (run_ff) begin
         coef_rd_ff <= coef_mem[caddr_ff];
      end
   end

   sfir_hist #(
      .DEPTH (HDEPTH),
      .AW    (HA_W),
      .WIDTH (SAMPLE_BITS)
   ) u_hist_l (
      .clock   (clock),
      .wr_en   (hwr_ff),
      .wr_addr (wrp_ff),
      .wr_data (new_l_ff),
      .rd_en   (run_ff),
      .rd_addr (rdp_ff),
      .rd_data (hist_l)
   );

   sfir_hist #(
      .DEPTH (HDEPTH),
      .AW    (HA_W),
      .WIDTH (SAMPLE_BITS)
   ) u_hist_r (
      .clock   (clock),
      .wr_en   (hwr_ff),
      .wr_addr (wrp_ff),
      .wr_data (new_r_ff),
      .rd_en   (run_ff),
      .rd_addr (rdp_ff),
      .rd_data (hist_r)
   );

   sfir_mac #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mac_l (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl_ff),
      .newest (new_l_ff),
      .hist   (hist_l),
      .coef   (coef_rd_ff),
      .res    (res_l),
      .done   (done_l)
   );

   sfir_mac #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mac_r (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl_ff),
      .newest (new_r_ff),
      .hist   (hist_r),
      .coef   (coef_rd_ff),
      .res    (res_r),
      .done   (done_r)
   );

   assign rsp_valid     = out_valid_ff;
   assign rsp_left_out  = out_l_ff;
   assign rsp_right_out = out_r_ff;

   // Both lanes run in lockstep and finish on the same cycle.
   a_lanes_together: assert property (@(posedge clock) disable iff (reset)
      done_l == done_r)
      else $error("channel lanes finished on different cycles");

   // A finished filter result never lands on a held result.
   a_no_pend_overwrite: assert property (@(posedge clock) disable iff (reset)
      done_l |-> !pend_valid_ff)
      else $error("lane result would overwrite a pending result");

   // The last tap read is followed by the history write of the newest sample.
   a_hist_after_last: assert property (@(posedge clock) disable iff (reset)
      run_ff && tap_last |=> hwr_ff && !run_ff)
      else $error("history write did not follow the last tap");

   // No history write while taps are still being read.
   a_no_write_in_run: assert property (@(posedge clock) disable iff (reset)
      hwr_ff |-> !run_ff)
      else $error("history written during the tap loop");

endmodule
`default_nettype wire
